// ===== hdl/sha1md_pkg.sv =====
// Shared types and constants of the SHA-1 message digest block.
package sha1md_pkg;

    // Working variables of the compression rounds.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

    localparam int unsigned CHAIN_WORDS = 5;
    localparam int unsigned BLOCK_WORDS = 16;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] SCHED_LOAD_ROUNDS = 7'd16;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

endpackage

// ===== hdl/sha1md_round.sv =====
// One SHA-1 compression round: round function, constant select and the five-way add.
module sha1md_round (
    input  sha1md_pkg::t_vars i_vars,
    input  logic [31:0]       i_w,
    input  logic [6:0]        i_rnd,
    output sha1md_pkg::t_vars o_vars
);
    import sha1md_pkg::*;

    logic [31:0] f;
    logic [31:0] k;

    always_comb begin
        if (i_rnd < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_00_19;
        end else if (i_rnd < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_20_39;
        end else if (i_rnd < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_40_59;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_60_79;
        end
    end

    always_comb begin
        o_vars.a = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + k + i_w;
        o_vars.b = i_vars.a;
        o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

// ===== hdl/sha1_message_digest_top.sv =====
// Top level of the SHA-1 message digest block: byte packing, padding, sequencing and memories.
//
//  Channel   | Direction | tdata             | tuser          | tlast
//  ----------+-----------+-------------------+----------------+---------------
//  s_axis    | in        | [7:0] data_byte   | [0] byte_pres. | end_of_message
//  m_axis    | out       | [31:0] digest_w.  | [2:0] word_idx | last_word
//
// A message byte is taken while the block is idle. The 64th byte of a
// block starts a compression: the chaining words are loaded from the chain
// memory, the 80 rounds run, and the read-add-write back follows.
// The chain memory port is the shared resource that sets the load and write-back time.
// An end-of-message request is followed by the padding bytes, one per cycle (up to 72)
// outside a compression, one or two compressions, the digest word reads and the pass
// restoring the initial chaining values. Input is not taken during any of this.
// After reset the same pass writes the initial chaining values before the
// first request is taken. A stalled output holds the next digest word back; the
// last word may wait in the output register while a new message is already loading.
module sha1_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha1md_pkg::*;

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,  // write initial chaining values
        S_IDLE = 8'b0000_0010,  // take message bytes
        S_PAD  = 8'b0000_0100,  // append padding and length bytes
        S_CLD  = 8'b0000_1000,  // load working variables from chain memory
        S_RND  = 8'b0001_0000,  // 80 compression rounds
        S_CWB  = 8'b0010_0000,  // add working variables into chain memory
        S_ORD  = 8'b0100_0000,  // read one digest word
        S_OWR  = 8'b1000_0000   // place the digest word in the output register
    } t_state;

    t_state r_state, n_state;

    // Block buffer and chaining words live in two small synchronous memories.
    logic [31:0] r_blk_mem [BLOCK_WORDS];
    logic [31:0] r_chain_mem [CHAIN_WORDS];
    logic [31:0] r_blk_rd;
    logic [31:0] r_chain_rd;

    logic        blk_we;
    logic [3:0]  blk_waddr;
    logic [31:0] blk_wdata;
    logic        blk_re;
    logic [3:0]  blk_raddr;

    logic        chain_we;
    logic [2:0]  chain_waddr;
    logic [31:0] chain_wdata;
    logic        chain_re;
    logic [2:0]  chain_raddr;

    // Sequencing and message state.
    logic [2:0]  r_cnt, n_cnt;
    logic [6:0]  r_rnd, n_rnd;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_end, n_end;
    logic        r_mark, n_mark;
    logic        r_lenph, n_lenph;

    // Datapath registers.
    logic [23:0] r_part, n_part;
    t_vars       r_vars, n_vars;
    logic [31:0] r_w [BLOCK_WORDS];
    logic        sched_shift;
    logic [31:0] w_t;
    t_vars       round_vars;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [2:0]  r_out_index;
    logic        r_out_last;
    logic        out_load;

    // Byte path shared by message bytes and padding.
    logic        put_en;
    logic [7:0]  put_byte;
    logic        len_now;
    logic [7:0]  len_byte;
    logic        in_accept;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Length bytes go out most significant first, at buffer positions 56 to 63.
    assign len_now  = r_lenph || (r_mark && (r_fill == LEN_POS));
    assign len_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];

    assign w_t = (r_rnd < SCHED_LOAD_ROUNDS) ? r_blk_rd
               : rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);

    sha1md_round u_round (
        .i_vars (r_vars),
        .i_w    (w_t),
        .i_rnd  (r_rnd),
        .o_vars (round_vars)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rnd       = r_rnd;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_end       = r_end;
        n_mark      = r_mark;
        n_lenph     = r_lenph;
        n_part      = r_part;
        n_vars      = r_vars;
        sched_shift = 1'b0;
        out_load    = 1'b0;
        put_en      = 1'b0;
        put_byte    = s_axis_tdata;
        blk_we      = 1'b0;
        blk_waddr   = r_fill[5:2];
        blk_wdata   = {r_part, put_byte};
        blk_re      = 1'b0;
        blk_raddr   = r_rnd[3:0] + 4'd1;
        chain_we    = 1'b0;
        chain_waddr = r_cnt;
        chain_wdata = INIT_H[r_cnt];
        chain_re    = 1'b0;
        chain_raddr = r_cnt;

        case (r_state)
            S_INIT: begin
                chain_we = 1'b1;
                n_cnt    = r_cnt + 3'd1;
                n_bits   = '0;
                n_fill   = '0;
                n_end    = 1'b0;
                n_mark   = 1'b0;
                n_lenph  = 1'b0;
                if (r_cnt == 3'd4) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    put_en = s_axis_tuser;
                    n_end  = s_axis_tlast;
                    if (s_axis_tuser) begin
                        n_bits = r_bits + 64'd8;
                    end
                    if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                put_en = 1'b1;
                if (!r_mark) begin
                    put_byte = PAD_MARK;
                end else if (len_now) begin
                    put_byte = len_byte;
                end else begin
                    put_byte = 8'h00;
                end
                n_mark  = 1'b1;
                n_lenph = len_now;
            end
            S_CLD: begin
                chain_re = (r_cnt != 3'd5);
                if (r_cnt != 3'd0) begin
                    n_vars = '{a: r_vars.b, b: r_vars.c, c: r_vars.d, d: r_vars.e,
                               e: r_chain_rd};
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    blk_re    = 1'b1;
                    blk_raddr = '0;
                    n_cnt     = '0;
                    n_rnd     = '0;
                    n_state   = S_RND;
                end
            end
            S_RND: begin
                blk_re      = 1'b1;
                sched_shift = 1'b1;
                n_vars      = round_vars;
                n_rnd       = r_rnd + 7'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_cnt   = '0;
                    n_state = S_CWB;
                end
            end
            S_CWB: begin
                chain_re = (r_cnt != 3'd5);
                if (r_cnt != 3'd0) begin
                    chain_we    = 1'b1;
                    chain_waddr = r_cnt - 3'd1;
                    chain_wdata = r_chain_rd + r_vars.a;
                    n_vars      = '{a: r_vars.b, b: r_vars.c, c: r_vars.d, d: r_vars.e,
                                    e: r_vars.a};
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    n_cnt = '0;
                    if (!r_end) begin
                        n_state = S_IDLE;
                    end else if (r_lenph) begin
                        n_state = S_ORD;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ORD: begin
                // Wait for a free output register so the read data has a place to go.
                if (!r_out_valid) begin
                    chain_re = 1'b1;
                    n_state  = S_OWR;
                end
            end
            S_OWR: begin
                out_load = 1'b1;
                n_cnt    = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_cnt   = '0;
                    n_state = S_INIT;
                end else begin
                    n_state = S_ORD;
                end
            end
            default: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
        endcase

        // Bytes are gathered into a word; the fourth byte writes the word to the buffer.
        if (put_en) begin
            blk_wdata = {r_part, put_byte};
            if (r_fill[1:0] == 2'd3) begin
                blk_we = 1'b1;
            end else begin
                n_part = {r_part[15:0], put_byte};
            end
            n_fill = r_fill + 6'd1;
            if (r_fill == LAST_POS) begin
                n_cnt   = '0;
                n_state = S_CLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_fill      <= '0;
            r_bits      <= '0;
            r_end       <= 1'b0;
            r_mark      <= 1'b0;
            r_lenph     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rnd   <= n_rnd;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_end   <= n_end;
            r_mark  <= n_mark;
            r_lenph <= n_lenph;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_vars <= n_vars;
        if (sched_shift) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= w_t;
        end
        if (out_load) begin
            r_out_data  <= r_chain_rd;
            r_out_index <= r_cnt;
            r_out_last  <= (r_cnt == 3'd4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk_mem[blk_waddr] <= blk_wdata;
        end
        if (blk_re) begin
            r_blk_rd <= r_blk_mem[blk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_we) begin
            r_chain_mem[chain_waddr] <= chain_wdata;
        end
        if (chain_re) begin
            r_chain_rd <= r_chain_mem[chain_raddr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_index;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== dv/tb_sha1_message_digest_top.sv =====
// Self-checking testbench for the SHA-1 message digest block with a built-in SHA-1 predictor.
`timescale 1ns / 100ps

module tb_sha1_message_digest_top;

    // Initial chaining values and round constants of SHA-1.
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [31:0] RK_CHOOSE = 32'h5A827999;
    localparam logic [31:0] RK_PARITY_LO = 32'h6ED9EBA1;
    localparam logic [31:0] RK_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] RK_PARITY_HI = 32'hCA62C1D6;

    // Padding starts with this byte; the bit length begins at this buffer position.
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LENGTH_FIELD_POS = 6'd56;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam int unsigned DIGEST_WORDS = 5;

    // Run shape.
    localparam int unsigned TARGET_REQUESTS = 310;
    localparam int unsigned LONG_HOLD_CYCLES = 600;
    // One digest can take two compressions, up to 72 padding bytes and the word output.
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned WATCHDOG_NS = 5000000;

    // Ready patterns of the digest receiver.
    typedef enum int unsigned {
        RX_STEADY,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_pattern;

    // One expected digest word with its side fields.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  position;
        logic        is_last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;  // [0] byte_present
    logic        s_axis_tlast = 1'b0;  // end_of_message

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] digest_word
    logic [2:0]  m_axis_tuser;         // [2:0] word_index
    logic        m_axis_tlast;         // last_word

    sha1_message_digest_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // SHA-1 predictor state: chaining words, the partly filled block,
    // the running message length in bits and the byte fill of the block.
    // ------------------------------------------------------------------
    logic [31:0]  hash_state [DIGEST_WORDS];
    logic [31:0]  block_words [16];
    logic [63:0]  msg_bit_len;
    logic [5:0]   block_fill;

    // Digest words predicted but not yet seen on the output, oldest first.
    t_digest_word digest_words_due [$];

    int unsigned  mismatches = 0;
    int unsigned  words_checked = 0;
    int unsigned  requests_sent = 0;

    // Sender burst state; gapless turns idle gaps off for a stretch.
    int unsigned  burst_left = 0;
    bit           gapless = 1'b0;

    // The pressure test toggles this to ask the receiver for a long hold-off.
    bit           hold_req = 1'b0;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void restart_hash();
        hash_state[0] = H0_INIT;
        hash_state[1] = H1_INIT;
        hash_state[2] = H2_INIT;
        hash_state[3] = H3_INIT;
        hash_state[4] = H4_INIT;
        msg_bit_len = '0;
        block_fill = '0;
    endfunction

    // Eighty rounds over the full block, then add into the chaining words.
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int unsigned i;
        for (i = 0; i < 16; i++) w[i] = block_words[i];
        for (i = 16; i < 80; i++)
            w[i] = rotate_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = RK_CHOOSE;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = RK_PARITY_LO;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK_MAJORITY;
            end else begin
                f = b ^ c ^ d;
                k = RK_PARITY_HI;
            end
            t = rotate_left(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // Bytes fill each word from the most significant end.
    function automatic void absorb_byte(input logic [7:0] value);
        int unsigned shift;
        shift = (3 - block_fill[1:0]) * 8;
        block_words[block_fill[5:2]][shift +: 8] = value;
        if (block_fill == BLOCK_LAST_POS) compress_block();
        block_fill = block_fill + 6'd1;
    endfunction

    // Works out what one accepted request does, queueing any digest words it causes.
    function automatic void predict_request(input logic [7:0] value, input logic present,
                                            input logic eom);
        logic [63:0] length_bits;
        int unsigned i;
        if (present) begin
            absorb_byte(value);
            msg_bit_len += 64'd8;
        end
        if (eom) begin
            length_bits = msg_bit_len;
            absorb_byte(PAD_BYTE);
            while (block_fill != LENGTH_FIELD_POS) absorb_byte(8'h00);
            for (i = 0; i < 8; i++) absorb_byte(length_bits[8 * (7 - i) +: 8]);
            for (i = 0; i < DIGEST_WORDS; i++)
                digest_words_due.push_back('{word: hash_state[i], position: 3'(i),
                                             is_last: (i == DIGEST_WORDS - 1)});
            restart_hash();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Sender. Requests go out in bursts of random length separated by
    // random idle gaps, unless gapless is set. The task returns at the
    // edge where the request was accepted and leaves tvalid high, so a
    // following request goes out back to back. The prediction is made
    // at the acceptance edge.
    // ------------------------------------------------------------------
    task automatic offer_request(input logic [7:0] value, input logic present, input logic eom);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gapless ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tuser <= present;
        s_axis_tlast <= eom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(value, present, eom);
        if (present || eom) requests_sent++;
    endtask

    // Idle request: no byte and no end marker, with random noise on the data bits.
    task automatic offer_idle();
        offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    // One message of random bytes. It either closes on its last byte or with
    // a bare end marker; an empty message always takes the bare marker.
    task automatic send_message(input int unsigned len, input bit bare_end, input bit noisy);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 7) == 0) offer_idle();
            offer_request(8'($urandom_range(0, 255)), 1'b1,
                          !bare_end && len != 0 && i == len - 1);
        end
        if (bare_end || len == 0)
            offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // The sender stops and waits until every predicted digest word has come.
    task automatic pause_until_digests_done();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (digest_words_due.size() == 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // A bare end marker right after reset: the digest of the empty message.
    task automatic test_empty_message();
        offer_request(8'hA5, 1'b0, 1'b1);
    endtask

    // The classic three-byte message, closed on its last byte.
    task automatic test_short_message();
        offer_request(8'h61, 1'b1, 1'b0);
        offer_request(8'h62, 1'b1, 1'b0);
        offer_request(8'h63, 1'b1, 1'b1);
    endtask

    // Extreme byte values, single-byte messages that end on their byte, and
    // idle requests between bytes that must change nothing.
    task automatic test_byte_extremes_and_idle();
        offer_request(8'h00, 1'b1, 1'b1);
        offer_request(8'hFF, 1'b1, 1'b1);
        offer_request(8'hFF, 1'b0, 1'b0);
        offer_request(8'h00, 1'b1, 1'b0);
        offer_request(8'h00, 1'b0, 1'b0);
        offer_request(8'hFF, 1'b1, 1'b0);
        offer_request(8'h5A, 1'b0, 1'b0);
        offer_request(8'hFF, 1'b0, 1'b1);
        // A message straight after a digest must start from the initial chaining words.
        offer_request(8'h80, 1'b1, 1'b0);
        offer_request(8'h7F, 1'b1, 1'b1);
    endtask

    // Lengths around the padding limits: 55 bytes leave room for the length in
    // the same block, 56 and 63 force a second block, 64 fill one block exactly.
    task automatic test_padding_boundaries();
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b1, 1'b1);
        gapless = 1'b1;
        send_message(63, 1'b0, 1'b0);
        gapless = 1'b0;
        send_message(64, 1'b0, 1'b1);
    endtask

    // The receiver holds off for a long stretch while short messages keep coming,
    // so the output backs up and the block has to stall its input.
    task automatic test_output_hold_off();
        int unsigned n;
        hold_req <= ~hold_req;
        gapless = 1'b1;
        for (n = 0; n < 4; n++)
            send_message($urandom_range(0, 6), 1'($urandom_range(0, 1)), 1'b0);
        gapless = 1'b0;
    endtask

    // Mostly short messages, some longer ones, random ends, idle noise and
    // stretches without sender gaps.
    task automatic test_random_messages();
        int unsigned len;
        while (requests_sent < TARGET_REQUESTS) begin
            if ($urandom_range(0, 4) == 0) len = $urandom_range(13, 70);
            else len = $urandom_range(0, 12);
            gapless = ($urandom_range(0, 4) == 0);
            send_message(len, ($urandom_range(0, 2) == 0), 1'b1);
        end
        gapless = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver. It changes between steady, random and sparse ready patterns
    // at random intervals. A toggle of hold_req starts a long hold-off that
    // is counted here, in cycles.
    // ------------------------------------------------------------------
    bit           hold_seen = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  pattern_left = 0;
    t_rx_pattern  rx_pattern = RX_STEADY;

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 2));
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (rx_pattern)
                RX_STEADY: begin
                    m_axis_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 5) == 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker. Every accepted digest word is compared field by field with
    // the oldest prediction; a word with nothing predicted is a failure.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_digest_word due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected digest word %h", m_axis_tdata));
            end else begin
                due = digest_words_due.pop_front();
                if (m_axis_tdata !== due.word)
                    report_mismatch($sformatf("word %0d: digest_word %h, expected %h",
                                              words_checked, m_axis_tdata, due.word));
                if (m_axis_tuser !== due.position)
                    report_mismatch($sformatf("word %0d: word_index %0d, expected %0d",
                                              words_checked, m_axis_tuser, due.position));
                if (m_axis_tlast !== due.is_last)
                    report_mismatch($sformatf("word %0d: last_word %b, expected %b",
                                              words_checked, m_axis_tlast, due.is_last));
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence. Reset is held at the start and then released for
    // good; the block writes its initial chaining words by itself before it takes
    // the first request, which the handshake absorbs. Between the padding
    // test and the hold-off test the sender waits until every digest word
    // has come. At the end the run waits for the last digest and then for
    // long enough to catch any word the block should not have produced.
    // ------------------------------------------------------------------
    initial begin
        restart_hash();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_short_message();
        test_byte_extremes_and_idle();
        test_padding_boundaries();
        pause_until_digests_done();
        test_output_hold_off();
        pause_until_digests_done();
        test_random_messages();

        s_axis_tvalid <= 1'b0;
        wait (digest_words_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && digest_words_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(WATCHDOG_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sha1md_pkg.sv
hdl/sha1md_round.sv
hdl/sha1_message_digest_top.sv
dv/tb_sha1_message_digest_top.sv
